### hdl/brb_pkg.sv
// Shared types, constants and helpers for the byte ring buffer.
`default_nettype none

package brb_pkg;

    localparam int IDX_W     = 10;
    localparam int DEPTH     = 1 << IDX_W;
    localparam int CAP_W     = IDX_W + 1;
    localparam int CNT_W     = 16;
    localparam int MAX_BURST = 64;
    localparam int BURST_W   = $clog2(MAX_BURST + 1);
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(2);
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);

    typedef enum logic [3:0] {
        CMD_WRITE_BEGIN   = 4'd0,
        CMD_WRITE_DATA    = 4'd1,
        CMD_READ          = 4'd2,
        CMD_PEEK          = 4'd3,
        CMD_WRITE_RESERVE = 4'd4,
        CMD_WRITE_COMMIT  = 4'd5,
        CMD_READ_RESERVE  = 4'd6,
        CMD_DROP          = 4'd7,
        CMD_RESET         = 4'd8
    } brb_cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_NO_SPACE = 3'd2,
        ST_NO_DATA  = 3'd3,
        ST_NO_WRITE = 3'd4
    } brb_status_t;

    typedef enum logic [1:0] {
        JOB_SINGLE = 2'd0,
        JOB_WRITE  = 2'd1,
        JOB_READ   = 2'd2
    } brb_kind_t;

    // One queued unit of work for the back end
    typedef struct packed {
        brb_kind_t          kind;
        brb_status_t        status;
        logic [IDX_W-1:0]   granted;
        logic [IDX_W-1:0]   span_start;
        logic [IDX_W-1:0]   span_first_len;
        logic [IDX_W-1:0]   span_second_len;
        logic [IDX_W-1:0]   addr;
        logic [7:0]         data;
        logic [BURST_W-1:0] rd_count;
        logic [IDX_W-1:0]   w_after;
        logic [IDX_W-1:0]   r_after;
    } brb_job_t;

    typedef struct packed {
        brb_status_t      status;
        logic [7:0]       data_out;
        logic [IDX_W-1:0] granted;
        logic [IDX_W-1:0] span_start;
        logic [IDX_W-1:0] span_first_len;
        logic [IDX_W-1:0] span_second_len;
        logic [IDX_W-1:0] used_bytes;
        logic [IDX_W-1:0] free_bytes;
        logic             last;
    } brb_result_t;

    // Input tdata layout, lowest field last
    typedef struct packed {
        logic [6:0]       pad;
        logic [7:0]       data_in;
        logic             force_req;
        logic [CNT_W-1:0] count;
    } brb_in_word_t;

    // Output tdata layout, lowest field last
    typedef struct packed {
        logic             pad;
        logic [IDX_W-1:0] free_bytes;
        logic [IDX_W-1:0] used_bytes;
        logic [IDX_W-1:0] span_second_len;
        logic [IDX_W-1:0] span_first_len;
        logic [IDX_W-1:0] span_start;
        logic [IDX_W-1:0] granted;
        logic [7:0]       data_out;
        logic [2:0]       status;
    } brb_out_word_t;

    function automatic logic [CAP_W-1:0] brb_clamp_cap(input logic [CAP_W-1:0] v);
        logic [CAP_W-1:0] c;
        begin
            c = v;
            if (c < CAP_MIN) c = CAP_MIN;
            if (c > CAP_MAX) c = CAP_MAX;
            return c;
        end
    endfunction

    // idx < cap and step <= cap, so one conditional subtract wraps
    function automatic logic [IDX_W-1:0] brb_wrap(input logic [IDX_W-1:0] idx,
                                                  input logic [IDX_W-1:0] step,
                                                  input logic [CAP_W-1:0] cap);
        logic [CAP_W:0] s;
        begin
            s = {2'b00, idx} + {2'b00, step};
            if (s >= {1'b0, cap}) s = s - {1'b0, cap};
            return s[IDX_W-1:0];
        end
    endfunction

    function automatic logic [IDX_W-1:0] brb_used(input logic [IDX_W-1:0] w,
                                                  input logic [IDX_W-1:0] r,
                                                  input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] d;
        begin
            if (w >= r) d = {1'b0, w} - {1'b0, r};
            else        d = {1'b0, w} + cap - {1'b0, r};
            return d[IDX_W-1:0];
        end
    endfunction

    function automatic logic [IDX_W-1:0] brb_free(input logic [IDX_W-1:0] used,
                                                  input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] d;
        begin
            d = cap - CAP_W'(1) - {1'b0, used};
            return d[IDX_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### hdl/brb_front.sv
// Front end: decodes commands, owns the indices and open-write state, issues jobs.
`default_nettype none

module brb_front
    import brb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire logic [3:0]       command,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic             force_req,
    input  wire logic [7:0]       data_in,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data,
    input  wire logic             q_full,
    output logic                  q_push,
    output brb_job_t              q_job,
    output logic [CAP_W-1:0]      cap
);

    logic [CAP_W-1:0] cap_reg;
    logic [IDX_W-1:0] r_reg, r_next;
    logic [IDX_W-1:0] w_reg, w_next;
    logic [IDX_W-1:0] left_reg, left_next;
    logic [IDX_W-1:0] off_reg, off_next;
    logic             auto_reg, auto_next;

    logic [IDX_W-1:0] used, room, g_room, g_used, g;
    logic             gt_room, gt_used;
    logic [CAP_W-1:0] wtail, rtail;
    logic [IDX_W-1:0] wn1, wn2, rn1, rn2;
    brb_job_t         job;

    assign cap        = cap_reg;
    assign cfg_ready  = 1'b1;
    assign item_ready = !q_full;
    assign q_push     = item_valid && item_ready;
    assign q_job      = job;

    assign used    = brb_used(w_reg, r_reg, cap_reg);
    assign room    = brb_free(used, cap_reg);
    assign gt_room = count > {{(CNT_W-IDX_W){1'b0}}, room};
    assign gt_used = count > {{(CNT_W-IDX_W){1'b0}}, used};
    assign g_room  = gt_room ? room : count[IDX_W-1:0];
    assign g_used  = gt_used ? used : count[IDX_W-1:0];

    // write region splits at the end of the store; a zero read index costs one slot
    assign wtail = cap_reg - {1'b0, w_reg} - ((r_reg == '0) ? CAP_W'(1) : CAP_W'(0));
    assign wn1   = (w_reg < r_reg || {1'b0, g_room} < wtail) ? g_room : wtail[IDX_W-1:0];
    assign wn2   = g_room - wn1;
    assign rtail = cap_reg - {1'b0, r_reg};
    assign rn1   = (r_reg < w_reg || {1'b0, g_used} < rtail) ? g_used : rtail[IDX_W-1:0];
    assign rn2   = g_used - rn1;

    always_comb
    begin
        r_next    = r_reg;
        w_next    = w_reg;
        left_next = left_reg;
        off_next  = off_reg;
        auto_next = auto_reg;
        g         = '0;
        job       = '0;
        job.kind  = JOB_SINGLE;
        job.status = ST_OK;
        job.data  = data_in;

        unique case (brb_cmd_t'(command)) inside
            CMD_WRITE_BEGIN:
            begin
                if (count == '0)                job.status = ST_INVALID;
                else if (gt_room && !force_req) job.status = ST_NO_SPACE;
                else
                begin
                    g = g_room;
                    if (g != '0)
                    begin
                        left_next = g;
                        off_next  = '0;
                        auto_next = 1'b1;
                    end
                end
            end
            CMD_WRITE_DATA:
            begin
                if (left_reg == '0) job.status = ST_NO_WRITE;
                else
                begin
                    job.kind  = JOB_WRITE;
                    job.addr  = brb_wrap(w_reg, off_reg, cap_reg);
                    g         = IDX_W'(1);
                    off_next  = off_reg + IDX_W'(1);
                    left_next = left_reg - IDX_W'(1);
                    if (left_reg == IDX_W'(1) && auto_reg)
                    begin
                        w_next    = brb_wrap(w_reg, off_reg + IDX_W'(1), cap_reg);
                        left_next = '0;
                        off_next  = '0;
                        auto_next = 1'b0;
                    end
                end
            end
            CMD_READ, CMD_PEEK:
            begin
                if (count == '0 || count > CNT_W'(MAX_BURST)) job.status = ST_INVALID;
                else if (gt_used && !force_req)                 job.status = ST_NO_DATA;
                else
                begin
                    g = g_used;
                    if (g != '0)
                    begin
                        job.kind     = JOB_READ;
                        job.addr     = r_reg;
                        job.rd_count = g[BURST_W-1:0];
                        if (brb_cmd_t'(command) == CMD_READ)
                            r_next = brb_wrap(r_reg, g, cap_reg);
                    end
                end
            end
            CMD_WRITE_RESERVE:
            begin
                if (gt_room && !force_req) job.status = ST_NO_SPACE;
                else if (g_room == '0)
                begin
                    left_next = '0;
                    off_next  = '0;
                    auto_next = 1'b0;
                end
                else
                begin
                    g                   = g_room;
                    job.span_start      = w_reg;
                    job.span_first_len  = wn1;
                    job.span_second_len = wn2;
                    left_next           = g_room;
                    off_next            = '0;
                    auto_next           = 1'b0;
                end
            end
            CMD_READ_RESERVE:
            begin
                if (gt_used && !force_req) job.status = ST_NO_DATA;
                else if (g_used != '0)
                begin
                    g                   = g_used;
                    job.span_start      = r_reg;
                    job.span_first_len  = rn1;
                    job.span_second_len = rn2;
                end
            end
            CMD_WRITE_COMMIT:
            begin
                if (gt_room) job.status = ST_NO_SPACE;
                else
                begin
                    g         = count[IDX_W-1:0];
                    w_next    = brb_wrap(w_reg, count[IDX_W-1:0], cap_reg);
                    left_next = '0;
                    off_next  = '0;
                    auto_next = 1'b0;
                end
            end
            CMD_DROP:
            begin
                if (gt_used && !force_req) job.status = ST_NO_DATA;
                else
                begin
                    g      = g_used;
                    r_next = brb_wrap(r_reg, g_used, cap_reg);
                end
            end
            CMD_RESET:
            begin
                r_next    = '0;
                w_next    = '0;
                left_next = '0;
                off_next  = '0;
                auto_next = 1'b0;
            end
            default:
            begin
                job.status = ST_INVALID;
            end
        endcase

        job.granted = g;
        job.w_after = w_next;
        job.r_after = r_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAP_MAX;
            r_reg    <= '0;
            w_reg    <= '0;
            left_reg <= '0;
            off_reg  <= '0;
            auto_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg  <= brb_clamp_cap(cfg_data);
            r_reg    <= '0;
            w_reg    <= '0;
            left_reg <= '0;
            off_reg  <= '0;
            auto_reg <= 1'b0;
        end
        else if (q_push)
        begin
            r_reg    <= r_next;
            w_reg    <= w_next;
            left_reg <= left_next;
            off_reg  <= off_next;
            auto_reg <= auto_next;
        end
    end

endmodule

`default_nettype wire

### hdl/brb_queue.sv
// Short job FIFO between the front and back ends.
`default_nettype none

module brb_queue
    import brb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire brb_job_t push_job,
    output logic          full,
    input  wire logic     pop,
    output logic          head_valid,
    output brb_job_t      head_job
);

    brb_job_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;

    assign full       = fill_reg == (QPTR_W+1)'(QDEPTH);
    assign head_valid = fill_reg != '0;
    assign head_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + (QPTR_W+1)'(1);
                2'b01:   fill_reg <= fill_reg - (QPTR_W+1)'(1);
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/brb_back.sv
// Back end: byte store, read-burst sequencer and two result stages.
`default_nettype none

module brb_back
    import brb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CAP_W-1:0] cap,
    input  wire logic             q_valid,
    input  wire brb_job_t         q_job,
    output logic                  q_pop,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output brb_result_t           res
);

    logic [7:0]       mem [DEPTH];
    logic [7:0]       mem_q_reg;

    logic             a_valid_reg, a_mem_reg;
    brb_result_t      a_res_reg;
    logic             b_valid_reg;
    brb_result_t      b_res_reg;

    logic             burst_active_reg;
    logic [IDX_W-1:0] burst_addr_reg;
    logic [BURST_W-1:0] burst_left_reg;

    logic             b_load, a_free, take, is_read, is_write, last_byte;
    logic [IDX_W-1:0] cur_addr, mem_addr, next_addr, used_after;
    logic [BURST_W-1:0] cur_left;
    brb_result_t      a_new;
    brb_result_t      b_new;

    assign b_load    = a_valid_reg && (!b_valid_reg || res_ready);
    assign a_free    = !a_valid_reg || b_load;
    assign take      = q_valid && a_free;
    assign is_read   = q_job.kind == JOB_READ;
    assign is_write  = q_job.kind == JOB_WRITE;
    assign cur_addr  = burst_active_reg ? burst_addr_reg : q_job.addr;
    assign cur_left  = burst_active_reg ? burst_left_reg : q_job.rd_count;
    assign last_byte = cur_left == BURST_W'(1);
    assign q_pop     = take && (!is_read || last_byte);
    assign mem_addr  = is_write ? q_job.addr : cur_addr;
    assign next_addr = brb_wrap(cur_addr, IDX_W'(1), cap);
    assign used_after = brb_used(q_job.w_after, q_job.r_after, cap);

    assign res_valid = b_valid_reg;
    assign res       = b_res_reg;

    always_comb
    begin
        a_new                 = '0;
        a_new.status          = q_job.status;
        a_new.granted         = q_job.granted;
        a_new.span_start      = q_job.span_start;
        a_new.span_first_len  = q_job.span_first_len;
        a_new.span_second_len = q_job.span_second_len;
        a_new.used_bytes      = used_after;
        a_new.free_bytes      = brb_free(used_after, cap);
        a_new.last            = is_read ? last_byte : 1'b1;
    end

    // merge the registered store byte into a read result
    always_comb
    begin
        b_new          = a_res_reg;
        b_new.data_out = a_mem_reg ? mem_q_reg : 8'd0;
    end

    // store: one write or one read per cycle, read data registered
    always_ff @(posedge clk)
    begin
        if (take && is_write) mem[mem_addr] <= q_job.data;
        if (take && is_read)  mem_q_reg     <= mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (take) a_res_reg <= a_new;
        if (take) a_mem_reg <= is_read;
        if (b_load) b_res_reg <= b_new;
        if (take && is_read)
        begin
            burst_addr_reg <= next_addr;
            burst_left_reg <= cur_left - BURST_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            burst_active_reg <= 1'b0;
        end
        else
        begin
            if (take)        a_valid_reg <= 1'b1;
            else if (b_load) a_valid_reg <= 1'b0;

            if (b_load)         b_valid_reg <= 1'b1;
            else if (res_ready) b_valid_reg <= 1'b0;

            if (take && is_read) burst_active_reg <= !last_byte;
        end
    end

endmodule

`default_nettype wire

### hdl/byte_ring_buffer_reserve_commit.sv
// Top level of the byte ring buffer with reserve and commit commands.
`default_nettype none

// Byte ring buffer that keeps one slot empty, with a run-time capacity of
// 2..1024 bytes (set through the cfg channel; a cfg transaction also empties
// the buffer and closes any open write). Commands arrive on the s_ side, one
// per transaction, and results leave on the m_ side: read and peek give one
// byte per result, everything else gives a single result, and tlast marks the
// final result of each command. The front end decodes a command in the cycle
// it is accepted and updates the indices right away, so it takes one command
// per clock while its 4-entry job queue has room. The back end drains the
// queue at one result per clock while the m_ side takes them: a read or peek
// of g bytes holds the queue head until its g results are out (one read of the
// single-port byte store each), so the next job starts only after the last
// byte of a burst. A result passes through the job queue and the A and B
// result stages before it is presented on m_tvalid. A full queue
// lowers s_tready; a stalled m_ side only backs up the queue. The byte store
// has no reset and needs no clearing pass as long as bytes are only read after
// they were written; the user is bound to that, the block does not enforce it.
module byte_ring_buffer_reserve_commit
    import brb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // command channel
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [31:0]      s_tdata,  // count[15:0], force_req[16], data_in[24:17], 0
    input  wire logic [3:0]       s_tuser,  // command[3:0]
    // result channel
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [71:0]           m_tdata,  // status[2:0], data_out[10:3],
                                            // granted[20:11], span_start[30:21],
                                            // span_first_len[40:31],
                                            // span_second_len[50:41],
                                            // used_bytes[60:51], free_bytes[70:61], 0
    output logic                  m_tlast,
    // capacity register write
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data
);

    brb_in_word_t  in_word;
    brb_out_word_t out_word;
    brb_job_t      push_job, head_job;
    brb_result_t   res;
    logic          q_full, q_push, q_pop, q_valid;
    logic [CAP_W-1:0] cap;

    assign in_word = brb_in_word_t'(s_tdata);

    brb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .command    (s_tuser),
        .count      (in_word.count),
        .force_req  (in_word.force_req),
        .data_in    (in_word.data_in),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job),
        .cap        (cap)
    );

    // jobs are carried out strictly in order, so a read that frees slots
    // finishes before a later write can land in them
    brb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    brb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap),
        .q_valid   (q_valid),
        .q_job     (head_job),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    always_comb
    begin
        out_word                 = '0;
        out_word.status          = res.status;
        out_word.data_out        = res.data_out;
        out_word.granted         = res.granted;
        out_word.span_start      = res.span_start;
        out_word.span_first_len  = res.span_first_len;
        out_word.span_second_len = res.span_second_len;
        out_word.used_bytes      = res.used_bytes;
        out_word.free_bytes      = res.free_bytes;
    end

    assign m_tdata = out_word;
    assign m_tlast = res.last;

endmodule

`default_nettype wire

### hdl/brb_checker.sv
// Port-level assertions for the byte ring buffer, bound to the top level.
`default_nettype none

module brb_checker
    import brb_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic [31:0]      s_tdata,
    input wire logic [3:0]       s_tuser,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [71:0]      m_tdata,
    input wire logic             m_tlast,
    input wire logic             cfg_valid,
    input wire logic             cfg_ready,
    input wire logic [CAP_W-1:0] cfg_data
);

    brb_out_word_t    ow;
    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] fill_sum;
    logic             unused_in;

    assign ow        = brb_out_word_t'(m_tdata);
    assign fill_sum  = {1'b0, ow.used_bytes} + {1'b0, ow.free_bytes};
    assign unused_in = s_tvalid & s_tready & (^s_tdata) & (^s_tuser);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)                       cap_reg <= CAP_MAX;
        else if (cfg_valid && cfg_ready)  cap_reg <= brb_clamp_cap(cfg_data);
    end

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // held plus writable always fills the capacity minus the spare slot
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> fill_sum == cap_reg - CAP_W'(1))
        else $error("used plus free does not match capacity");

    // an error ends the command and grants nothing
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ow.status != 3'(ST_OK) |-> m_tlast && ow.granted == '0)
        else $error("error result not final or with a grant");

    // a data byte only comes with a grant and never with a span
    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ow.data_out != 8'd0 && !unused_in |->
            ow.granted != '0 && ow.span_first_len == '0 && ow.span_second_len == '0)
        else $error("data byte on a non-read result");

endmodule

bind byte_ring_buffer_reserve_commit brb_checker u_brb_checker (.*);

`default_nettype wire

### dv/tb_byte_ring_buffer_reserve_commit.sv
// Self-checking random testbench for the byte ring buffer with reserve and commit.
module tb_byte_ring_buffer_reserve_commit;
    timeunit 1ns;
    timeprecision 1ps;

    import brb_pkg::*;

    // Cycles with no transaction on any channel before the run is declared hung.
    // The slowest legal silence is the receiver's long hold-off (HOLD_CYCLES)
    // plus a sender gap; this limit is over ten times that.
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    // Margin run after the last result is back, before the verdict.
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 200;
    localparam int PHASE_ITEMS  = 36;
    localparam int NUM_PHASES   = 9;
    // Capacity per random phase: small rings wrap constantly, 0 and 2047 are
    // out of range and must behave as 2 and 1024.
    localparam int PHASE_CAPS [NUM_PHASES] = '{16, 2, 37, 2047, 3, 0, 100, 1024, 5};
    // Phase in which the receiver holds off long enough to back up the block.
    localparam int FILL_PHASE   = 2;

    // One command as it travels on the s_ channel
    typedef struct {
        logic [3:0]       cmd;
        logic [CNT_W-1:0] count;
        logic             force_req;
        logic [7:0]       data_in;
    } ring_cmd_t;

    // Everything the block remembers, plus which store bytes were ever written
    typedef struct {
        logic [CAP_W-1:0] cap_setting;
        logic [IDX_W-1:0] rd_idx;
        logic [IDX_W-1:0] wr_idx;
        logic [IDX_W-1:0] open_left;
        logic [IDX_W-1:0] open_off;
        logic             open_auto;
        logic [7:0]       mem [DEPTH];
        bit               written [DEPTH];
    } ring_state_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;  // count[15:0], force_req[16], data_in[24:17], 0
    logic [3:0]           s_tuser   = '0;  // command[3:0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [71:0]          m_tdata;         // status[2:0], data_out[10:3], granted[20:11],
                                           // span_start[30:21], span_first_len[40:31],
                                           // span_second_len[50:41], used_bytes[60:51],
                                           // free_bytes[70:61], 0
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data  = '0;

    // plan_state runs ahead as commands are queued (used to shape stimulus);
    // ring_now follows the block, advanced when a transaction is accepted.
    ring_state_t          plan_state;
    ring_state_t          ring_now;
    ring_cmd_t            cmds_to_send [$];
    brb_result_t          results_due [$];
    int                   items_planned = 0;
    int                   bad_fields    = 0;
    int                   reports       = 0;
    bit                   cmd_taken     = 1'b0;
    bit                   fill_test_req = 1'b0;

    byte_ring_buffer_reserve_commit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Ring behavior
    // ------------------------------------------------------------------

    // Capacity actually in use: out-of-range settings clamp to 2..DEPTH
    function automatic int ring_cap(input logic [CAP_W-1:0] setting);
        int c;
        c = int'(setting);
        if (c < 2) c = 2;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    function automatic int ring_wrap(input int idx, input int step, input int cap);
        int s;
        s = idx + step;
        if (s >= cap) s = s - cap;
        if (s >= cap) s = s % cap;
        return s;
    endfunction

    function automatic void ring_close(inout ring_state_t st);
        st.open_left = '0;
        st.open_off  = '0;
        st.open_auto = 1'b0;
    endfunction

    function automatic void ring_clear(inout ring_state_t st);
        int k;
        for (k = 0; k < DEPTH; k++)
        begin
            st.mem[k]     = 8'h00;
            st.written[k] = 1'b0;
        end
        st.cap_setting = CAP_MAX;
        st.rd_idx      = '0;
        st.wr_idx      = '0;
        ring_close(st);
    endfunction

    // A capacity write also empties the ring and abandons an open write
    function automatic void ring_config(inout ring_state_t st, input logic [CAP_W-1:0] v);
        st.cap_setting = v;
        st.rd_idx      = '0;
        st.wr_idx      = '0;
        ring_close(st);
    endfunction

    // Applies one command; fills outs[0..n-1] and returns n
    function automatic int ring_step(inout ring_state_t st, input ring_cmd_t it,
                                     output brb_result_t outs [MAX_BURST]);
        int cap, r, w, used, room, lim, g, n1, n2, seg, tail, idx, n, k;
        bit wr;
        cap  = ring_cap(st.cap_setting);
        r    = int'(st.rd_idx);
        w    = int'(st.wr_idx);
        used = (w + cap - r) % cap;
        room = cap - 1 - used;
        g    = int'(it.count);
        n    = 1;
        n1   = 0;
        n2   = 0;
        for (k = 0; k < MAX_BURST; k++) outs[k] = '0;
        outs[0].status = ST_OK;

        case (it.cmd)
            CMD_WRITE_BEGIN:
            begin
                if (g == 0) outs[0].status = ST_INVALID;
                else if (g > room && !it.force_req) outs[0].status = ST_NO_SPACE;
                else
                begin
                    if (g > room) g = room;
                    // an empty forced grant opens nothing
                    if (g > 0)
                    begin
                        st.open_left = IDX_W'(g);
                        st.open_off  = '0;
                        st.open_auto = 1'b1;
                    end
                    outs[0].granted = IDX_W'(g);
                end
            end
            CMD_WRITE_DATA:
            begin
                if (int'(st.open_left) == 0) outs[0].status = ST_NO_WRITE;
                else
                begin
                    idx = ring_wrap(w, int'(st.open_off), cap);
                    st.mem[idx]     = it.data_in;
                    st.written[idx] = 1'b1;
                    st.open_off     = st.open_off + 1'b1;
                    st.open_left    = st.open_left - 1'b1;
                    // a write_begin burst commits itself on its last byte
                    if (int'(st.open_left) == 0 && st.open_auto)
                    begin
                        st.wr_idx = IDX_W'(ring_wrap(w, int'(st.open_off), cap));
                        ring_close(st);
                    end
                    outs[0].granted = IDX_W'(1);
                end
            end
            CMD_READ, CMD_PEEK:
            begin
                if (g == 0 || g > MAX_BURST) outs[0].status = ST_INVALID;
                else if (g > used && !it.force_req) outs[0].status = ST_NO_DATA;
                else
                begin
                    if (g > used) g = used;
                    // one result per byte; an empty grant still gives one result
                    if (g > 0)
                    begin
                        for (k = 0; k < g; k++)
                        begin
                            outs[k].status   = ST_OK;
                            outs[k].data_out = st.mem[ring_wrap(r, k, cap)];
                            outs[k].granted  = IDX_W'(g);
                        end
                        n = g;
                        if (it.cmd == CMD_READ) st.rd_idx = IDX_W'(ring_wrap(r, g, cap));
                    end
                end
            end
            CMD_WRITE_RESERVE, CMD_READ_RESERVE:
            begin
                wr  = (it.cmd == CMD_WRITE_RESERVE);
                lim = wr ? room : used;
                if (g > lim && !it.force_req)
                    outs[0].status = wr ? ST_NO_SPACE : ST_NO_DATA;
                else
                begin
                    if (g > lim) g = lim;
                    if (g == 0)
                    begin
                        // zero reserve reports nothing but closes an open write
                        if (wr) ring_close(st);
                    end
                    else
                    begin
                        // split the region at the end of the ring
                        if (wr)
                        begin
                            if (w < r)
                            begin
                                seg = r - w - 1;
                                n1  = (g < seg) ? g : seg;
                            end
                            else
                            begin
                                tail = cap - w;
                                if (r == 0) tail--;
                                n1 = (g < tail) ? g : tail;
                                n2 = g - n1;
                            end
                            st.open_left = IDX_W'(g);
                            st.open_off  = '0;
                            st.open_auto = 1'b0;
                        end
                        else
                        begin
                            if (r < w)
                            begin
                                seg = w - r;
                                n1  = (g < seg) ? g : seg;
                            end
                            else
                            begin
                                tail = cap - r;
                                n1   = (g < tail) ? g : tail;
                                n2   = g - n1;
                            end
                        end
                        outs[0].granted         = IDX_W'(n1 + n2);
                        outs[0].span_start      = IDX_W'(wr ? w : r);
                        outs[0].span_first_len  = IDX_W'(n1);
                        outs[0].span_second_len = IDX_W'(n2);
                    end
                end
            end
            CMD_WRITE_COMMIT:
            begin
                // force_req plays no part; a refused commit keeps the open write
                if (g > room) outs[0].status = ST_NO_SPACE;
                else
                begin
                    st.wr_idx = IDX_W'(ring_wrap(w, g, cap));
                    ring_close(st);
                    outs[0].granted = IDX_W'(g);
                end
            end
            CMD_DROP:
            begin
                if (g > used && !it.force_req) outs[0].status = ST_NO_DATA;
                else
                begin
                    if (g > used) g = used;
                    st.rd_idx       = IDX_W'(ring_wrap(r, g, cap));
                    outs[0].granted = IDX_W'(g);
                end
            end
            CMD_RESET:
            begin
                st.rd_idx = '0;
                st.wr_idx = '0;
                ring_close(st);
            end
            default: outs[0].status = ST_INVALID;
        endcase

        used = (int'(st.wr_idx) + cap - int'(st.rd_idx)) % cap;
        room = cap - 1 - used;
        for (k = 0; k < n; k++)
        begin
            outs[k].used_bytes = IDX_W'(used);
            outs[k].free_bytes = IDX_W'(room);
            outs[k].last       = (k == n - 1);
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus shaping
    // ------------------------------------------------------------------

    // True if a read or peek would fetch a store byte that was never written
    function automatic bit touches_unwritten(input ring_state_t st, input ring_cmd_t it);
        int cap, r, used, g, k;
        cap  = ring_cap(st.cap_setting);
        r    = int'(st.rd_idx);
        used = (int'(st.wr_idx) + cap - r) % cap;
        g    = int'(it.count);
        if (g == 0 || g > MAX_BURST) return 1'b0;
        if (g > used) g = it.force_req ? used : 0;
        for (k = 0; k < g; k++)
            if (!st.written[ring_wrap(r, k, cap)]) return 1'b1;
        return 1'b0;
    endfunction

    // Queues one command and returns the grant it will get
    function automatic int queue_cmd(input logic [3:0] cmd, input int count, input bit frc,
                                     input logic [7:0] din);
        ring_cmd_t   it;
        brb_result_t outs [MAX_BURST];
        it.cmd       = cmd;
        it.count     = CNT_W'(count);
        it.force_req = frc;
        it.data_in   = din;
        // the store has no reset: such a read becomes a drop of the same size
        if ((cmd == CMD_READ || cmd == CMD_PEEK) && touches_unwritten(plan_state, it))
            it.cmd = CMD_DROP;
        void'(ring_step(plan_state, it, outs));
        cmds_to_send.push_back(it);
        items_planned++;
        return int'(outs[0].granted);
    endfunction

    function automatic logic [7:0] rbyte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic bit rbit();
        return bit'($urandom_range(0, 1));
    endfunction

    // Mostly short lengths, sometimes long, rarely anything the field holds
    function automatic int pick_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return $urandom_range(1, 8);
        if (p < 90) return $urandom_range(9, 40);
        if (p < 97) return $urandom_range(41, 1100);
        return $urandom_range(0, 65535);
    endfunction

    function automatic void write_bytes(input int k);
        int i;
        for (i = 0; i < k; i++)
            void'(queue_cmd(CMD_WRITE_DATA, $urandom_range(0, 65535), rbit(), rbyte()));
    endfunction

    // One short random sequence: mostly well formed, some broken or noise
    function automatic void random_episode();
        int  pick, n, g, k;
        bit  frc;
        pick = $urandom_range(0, 99);
        frc  = rbit();
        if (pick < 28)
        begin
            // self-committing burst, now and then cut short or overrun
            g = queue_cmd(CMD_WRITE_BEGIN, pick_len(), frc, rbyte());
            k = (g > 48) ? 48 : g;
            if ($urandom_range(0, 9) == 0) k = $urandom_range(0, k);
            write_bytes(k);
            if ($urandom_range(0, 9) == 0) write_bytes(1);
        end
        else if (pick < 42)
        begin
            // reserve, fill some bytes, commit what was filled (or not quite)
            g = queue_cmd(CMD_WRITE_RESERVE, pick_len(), frc, rbyte());
            k = (g > 48) ? 48 : g;
            if ($urandom_range(0, 4) == 0) k = $urandom_range(0, k);
            write_bytes(k);
            n = $urandom_range(0, 9);
            if (n == 0) k = g;
            else if (n == 1) k = k + $urandom_range(1, 40);
            void'(queue_cmd(CMD_WRITE_COMMIT, k, rbit(), rbyte()));
        end
        else if (pick < 46)
        begin
            // big jump of both indices so large rings wrap too
            g = queue_cmd(CMD_WRITE_RESERVE, 65535, 1'b1, rbyte());
            k = (g < 5) ? g : 5;
            void'(queue_cmd(CMD_WRITE_COMMIT, g - $urandom_range(0, k), rbit(), rbyte()));
            void'(queue_cmd(CMD_DROP, $urandom_range(0, 1100), 1'b1, rbyte()));
        end
        else if (pick < 70)
        begin
            n = $urandom_range(0, 99);
            if (n < 80) k = $urandom_range(1, 12);
            else if (n < 95) k = $urandom_range(13, MAX_BURST);
            else k = rbit() ? 0 : $urandom_range(MAX_BURST + 1, 65535);
            void'(queue_cmd(($urandom_range(0, 3) == 0) ? CMD_PEEK : CMD_READ, k, frc,
                            rbyte()));
        end
        else if (pick < 78)
        begin
            g = queue_cmd(CMD_READ_RESERVE, pick_len(), frc, rbyte());
            if ($urandom_range(0, 4) < 3) void'(queue_cmd(CMD_DROP, g, 1'b0, rbyte()));
        end
        else if (pick < 86)
            void'(queue_cmd(CMD_DROP, pick_len(), frc, rbyte()));
        else if (pick < 93)
        begin
            n = $urandom_range(0, 3);
            if (n == 0)
                void'(queue_cmd(4'(CMD_RESET) + 4'($urandom_range(1, 7)),
                                $urandom_range(0, 65535), frc, rbyte()));
            else if (n == 1)
                void'(queue_cmd(CMD_RESET, $urandom_range(0, 65535), frc, rbyte()));
            else
                write_bytes(1);
        end
        else
            void'(queue_cmd(4'($urandom_range(0, 15)), $urandom_range(0, 65535), frc,
                            rbyte()));
    endfunction

    // ------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------

    // Rising edge: a command transaction moves the prediction forward
    always @(posedge clk)
    begin : cmd_accept
        brb_result_t outs [MAX_BURST];
        int          n;
        int          k;
        cmd_taken = rst_n && s_tvalid && s_tready;
        if (cmd_taken)
        begin
            n = ring_step(ring_now, cmds_to_send[0], outs);
            for (k = 0; k < n; k++) results_due.push_back(outs[k]);
            void'(cmds_to_send.pop_front());
        end
        if (rst_n && cfg_valid && cfg_ready) ring_config(ring_now, cfg_data);
    end

    // Falling edge: offer the next command in bursts with random gaps.
    // A command once offered stays on the bus until it is taken.
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk)
    begin : cmd_offer
        if (rst_n && !(s_tvalid && !cmd_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (cmds_to_send.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {7'b0, cmds_to_send[0].data_in, cmds_to_send[0].force_req,
                             cmds_to_send[0].count};
                s_tuser  <= cmds_to_send[0].cmd;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Receiver: switches between always ready, mostly ready and mostly stalled,
    // plus one long hold-off so the job queue fills and s_tready drops.
    int  rx_mode       = 0;
    int  rx_mode_left  = 0;
    int  hold_left     = 0;
    bit  fill_test_done = 1'b0;

    always @(negedge clk)
    begin : result_ready
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (fill_test_req && !fill_test_done)
        begin
            fill_test_done = 1'b1;
            hold_left      = HOLD_CYCLES;
            m_tready      <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(5, 60);
            end
            else
                rx_mode_left--;
            if (rx_mode == 0)
                m_tready <= 1'b1;
            else if (rx_mode == 1)
                m_tready <= ($urandom_range(0, 3) != 0);
            else
                m_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            bad_fields++;
            reports++;
            if (reports <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
        end
    endtask

    // Each result transaction is matched against the oldest outstanding one
    always @(posedge clk)
    begin : result_check
        brb_out_word_t got;
        brb_result_t   want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (results_due.size() == 0)
            begin
                bad_fields++;
                $display("%0t ns: unexpected result, expected none, actual tdata %h",
                         $time, m_tdata);
            end
            else
            begin
                want = results_due.pop_front();
                check_field("status",          int'(want.status),          int'(got.status));
                check_field("data_out",        int'(want.data_out),        int'(got.data_out));
                check_field("granted",         int'(want.granted),         int'(got.granted));
                check_field("span_start",      int'(want.span_start),      int'(got.span_start));
                check_field("span_first_len",  int'(want.span_first_len),
                            int'(got.span_first_len));
                check_field("span_second_len", int'(want.span_second_len),
                            int'(got.span_second_len));
                check_field("used_bytes",      int'(want.used_bytes),      int'(got.used_bytes));
                check_field("free_bytes",      int'(want.free_bytes),      int'(got.free_bytes));
                check_field("tlast",           int'(want.last),            int'(m_tlast));
            end
        end
    end

    // Watchdog: too long with no transaction anywhere means the block hung
    int quiet_cycles = 0;

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    // Idle: nothing queued, nothing on the bus, every result back
    task automatic wait_drained();
        while (cmds_to_send.size() != 0 || s_tvalid || results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_drained();
        ring_config(plan_state, value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : main_seq
        int ph;
        int first;
        ring_clear(plan_state);
        ring_clear(ring_now);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset capacity of 1024
        void'(queue_cmd(CMD_READ, 0, 1'b0, 8'h00));             // zero count: invalid
        void'(queue_cmd(CMD_PEEK, 0, 1'b1, 8'h00));
        void'(queue_cmd(CMD_WRITE_BEGIN, 0, 1'b1, 8'h00));
        void'(queue_cmd(CMD_WRITE_DATA, 0, 1'b0, 8'hFF));       // nothing open
        void'(queue_cmd(CMD_READ, 5, 1'b0, 8'h00));             // empty: not enough data
        void'(queue_cmd(CMD_READ, 5, 1'b1, 8'h00));             // empty forced grant
        void'(queue_cmd(CMD_WRITE_BEGIN, 65535, 1'b0, 8'h00));  // no space
        void'(queue_cmd(CMD_WRITE_BEGIN, 3, 1'b0, 8'h00));
        void'(queue_cmd(CMD_WRITE_DATA, 65535, 1'b1, 8'h00));
        void'(queue_cmd(CMD_WRITE_DATA, 0, 1'b0, 8'hFF));
        void'(queue_cmd(CMD_WRITE_DATA, 1, 1'b1, 8'hA5));
        void'(queue_cmd(CMD_PEEK, 3, 1'b0, 8'h00));
        void'(queue_cmd(CMD_READ, MAX_BURST + 1, 1'b1, 8'h00)); // above burst limit
        void'(queue_cmd(CMD_READ, MAX_BURST, 1'b1, 8'h00));     // forced down to 3
        void'(queue_cmd(CMD_WRITE_RESERVE, 0, 1'b0, 8'h00));    // zero reserve
        void'(queue_cmd(CMD_WRITE_RESERVE, 65535, 1'b1, 8'h00));// full ring, split span
        void'(queue_cmd(CMD_WRITE_DATA, 0, 1'b0, 8'h5A));
        void'(queue_cmd(CMD_WRITE_COMMIT, 65535, 1'b1, 8'h00)); // refused, stays open
        void'(queue_cmd(CMD_WRITE_COMMIT, 1, 1'b0, 8'h00));
        void'(queue_cmd(CMD_READ_RESERVE, 65535, 1'b1, 8'h00));
        void'(queue_cmd(CMD_DROP, 65535, 1'b0, 8'h00));
        void'(queue_cmd(CMD_DROP, 65535, 1'b1, 8'h00));
        void'(queue_cmd(4'(CMD_RESET) + 4'd7, 0, 1'b0, 8'h00)); // unknown command
        void'(queue_cmd(CMD_WRITE_BEGIN, 2, 1'b0, 8'h00));
        void'(queue_cmd(CMD_WRITE_BEGIN, 1, 1'b0, 8'h00));      // replaces the open one
        void'(queue_cmd(CMD_WRITE_DATA, 0, 1'b0, 8'h3C));
        void'(queue_cmd(CMD_RESET, 0, 1'b0, 8'h00));

        // Random phases, each at its own capacity
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_capacity(CAP_W'(PHASE_CAPS[ph]));
            first = items_planned;
            while (items_planned - first < PHASE_ITEMS) random_episode();
            if (ph == FILL_PHASE) fill_test_req = 1'b1;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_fields == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
hdl/brb_pkg.sv
hdl/brb_front.sv
hdl/brb_queue.sv
hdl/brb_back.sv
hdl/byte_ring_buffer_reserve_commit.sv
hdl/brb_checker.sv
dv/tb_byte_ring_buffer_reserve_commit.sv
